// File: rtl/qte_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler angle block.
// Used by the square-root cells, the CORDIC cells and the top level; depends on nothing.
`default_nettype none
package qte_pkg;

   localparam int W_IN   = 16;
   localparam int W_PROD = 32;
   localparam int W_OPER = 34;
   localparam int W_T    = 31;
   localparam int W_VEC  = 38;
   localparam int W_ANG  = 34;
   localparam int W_SQ   = 62;
   localparam int W_Q13  = 17;

   localparam int ISQ_STAGES = 31;

   localparam logic signed [W_ANG-1:0] HALF_PI_Q30    = W_ANG'(64'sd1686629713);
   localparam logic signed [W_ANG-1:0] QUARTER_PI_Q30 = W_ANG'(64'sd843314857);
   localparam logic signed [W_Q13-1:0] PI_Q13         = W_Q13'(25736);
   localparam logic signed [W_Q13-1:0] HALF_PI_Q13    = W_Q13'(12868);
   localparam logic [W_SQ-1:0]         ONE_Q60        = W_SQ'(1) << 60;
   localparam logic signed [W_OPER-1:0] UNIT_Q30      = W_OPER'(1) << 30;

   typedef struct packed {
      logic signed [W_VEC-1:0] x;
      logic signed [W_VEC-1:0] y;
      logic signed [W_ANG-1:0] z;
      logic                    zero;
   } cordic_vec_type;

   typedef struct packed {
      logic [W_SQ-1:0] n;
      logic [W_SQ-1:0] res;
   } isq_type;

   typedef struct packed {
      logic signed [W_OPER-1:0] yaw_n;
      logic signed [W_OPER-1:0] yaw_d;
      logic signed [W_OPER-1:0] roll_n;
      logic signed [W_OPER-1:0] roll_d;
      logic signed [W_T-1:0]    t;
      logic                     clamp_pos;
      logic                     clamp_neg;
   } side_type;

   // Floor quotient of two constants, one quotient bit per shift and subtract step.
   function automatic longint unsigned udiv_const(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int b;
      quo = 0;
      rem = 0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Rounded atan(2^-i) in the 2^30 angle scale, worked out at elaboration.
   function automatic longint atan_step(input int i);
      longint unsigned sum;
      longint unsigned term;
      int k;
      bit plus;
      sum  = 0;
      plus = 1'b1;
      if (i == 0) return longint'(QUARTER_PI_Q30);
      for (k = 1; k * i <= 60; k += 2) begin
         term = udiv_const(64'd1 << (60 - k * i), longint'(k));
         sum  = plus ? sum + term : sum - term;
         plus = !plus;
      end
      return longint'((sum + (64'd1 << 29)) >> 30);
   endfunction

   // Turns a left half-plane vector by a quarter turn before the stages.
   function automatic cordic_vec_type prerotate(input logic signed [W_VEC-1:0] y,
                                                input logic signed [W_VEC-1:0] x);
      cordic_vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            v.x = y;
            v.y = -x;
            v.z = HALF_PI_Q30;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -HALF_PI_Q30;
         end
      end
      return v;
   endfunction

   // Rounds a 2^30 scale angle to Q3.13 and saturates it to plus or minus lim.
   function automatic logic signed [W_Q13-1:0] to_q13(input logic signed [W_ANG-1:0] a,
                                                     input logic signed [W_Q13-1:0] lim);
      logic signed [W_ANG:0]    sum;
      logic signed [W_ANG-17:0] r;
      logic signed [W_ANG-17:0] lim_x;
      sum   = (W_ANG+1)'(a) + (W_ANG+1)'(65536);
      r     = (W_ANG-16)'(sum >>> 17);
      lim_x = (W_ANG-16)'(lim);
      if (r > lim_x) r = lim_x;
      if (r < -lim_x) r = -lim_x;
      return W_Q13'(r);
   endfunction

endpackage
`default_nettype wire

// File: rtl/qte_isqrt_cell.sv
// One restoring square-root cell: settles one root bit per cycle while enabled.
// Depends on qte_pkg for the operand struct.
`default_nettype none
module qte_isqrt_cell
   import qte_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire     clock,
   input  wire     en,
   input  isq_type d_in,
   output isq_type d_out
);

   localparam logic [W_SQ-1:0] BIT = W_SQ'(1) << (60 - 2 * STAGE);

   isq_type q_ff;
   isq_type q_in;
   logic [W_SQ-1:0] trial;

   always_comb begin
      trial = d_in.res + BIT;
      if (d_in.n >= trial) begin
         q_in.n   = d_in.n - trial;
         q_in.res = (d_in.res >> 1) + BIT;
      end else begin
         q_in.n   = d_in.n;
         q_in.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule
`default_nettype wire

// File: rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation cell with its own fixed angle step.
// Depends on qte_pkg for the vector struct and the angle table function.
`default_nettype none
module qte_cordic_cell
   import qte_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire            clock,
   input  wire            en,
   input  cordic_vec_type v_in,
   output cordic_vec_type v_out
);

   localparam logic signed [W_ANG-1:0] ANGLE = W_ANG'(atan_step(STAGE));

   cordic_vec_type v_ff;
   cordic_vec_type v_nx_in;
   logic signed [W_VEC-1:0] xs;
   logic signed [W_VEC-1:0] ys;

   always_comb begin
      xs = v_in.x >>> STAGE;
      ys = v_in.y >>> STAGE;
      v_nx_in.zero = v_in.zero;
      if (v_in.y >= 0) begin
         v_nx_in.x = v_in.x + ys;
         v_nx_in.y = v_in.y - xs;
         v_nx_in.z = v_in.z + ANGLE;
      end else begin
         v_nx_in.x = v_in.x - ys;
         v_nx_in.y = v_in.y + xs;
         v_nx_in.z = v_in.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) v_ff <= v_nx_in;
   end

   assign v_out = v_ff;

endmodule
`default_nettype wire

// File: rtl/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to ZYX Euler angle pipeline.
// Depends on qte_pkg, qte_isqrt_cell and qte_cordic_cell.
//
//   Channel | Direction | Item contents
//   req_    | in        | one quaternion: q_w, q_x, q_y, q_z (signed Q1.15 each)
//   rsp_   | out       | one angle set: yaw_angle, pitch_angle, roll_angle (Q3.13, pitch Q2.13)
//
// The block takes one item per cycle while the output is not held up; the depth
// is set by the 31 square-root cells and the CORDIC cells.
// Reset clears only the valid bits of the pipeline; data registers hold garbage.
// When the output register is full and not taken, the whole pipeline holds and
// req_tready drops in the same cycle; no item is ever dropped.
`default_nettype none
module quaternion_to_euler_angles_top
   import qte_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // q_w [15:0], q_x [31:16], q_y [47:32], q_z [63:48]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata    // yaw [15:0], pitch [30:16], roll [46:31], zero [47]
);

   localparam int LAT = 6 + ISQ_STAGES + CORDIC_STAGES;

   // A single enable moves every stage; it is high unless a result waits untaken.
   // No item is taken while reset is high.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];

   // Input registers.
   logic signed [W_IN-1:0] w_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= req_tdata[15:0];
         x_ff <= req_tdata[31:16];
         y_ff <= req_tdata[47:32];
         z_ff <= req_tdata[63:48];
      end
   end

   // All ten component products, each exact in 32 bits.
   logic signed [W_PROD-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [W_PROD-1:0] xy_ff, wz_ff, yz_ff, wx_ff, wy_ff, xz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= W_PROD'(w_ff) * W_PROD'(w_ff);
         xx_ff <= W_PROD'(x_ff) * W_PROD'(x_ff);
         yy_ff <= W_PROD'(y_ff) * W_PROD'(y_ff);
         zz_ff <= W_PROD'(z_ff) * W_PROD'(z_ff);
         xy_ff <= W_PROD'(x_ff) * W_PROD'(y_ff);
         wz_ff <= W_PROD'(w_ff) * W_PROD'(z_ff);
         yz_ff <= W_PROD'(y_ff) * W_PROD'(z_ff);
         wx_ff <= W_PROD'(w_ff) * W_PROD'(x_ff);
         wy_ff <= W_PROD'(w_ff) * W_PROD'(y_ff);
         xz_ff <= W_PROD'(x_ff) * W_PROD'(z_ff);
      end
   end

   // The ZYX product sums.
   logic signed [W_OPER-1:0] yaw_n_ff, yaw_d_ff, roll_n_ff, roll_d_ff, t_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_n_ff  <= (W_OPER'(xy_ff) + W_OPER'(wz_ff)) <<< 1;
         yaw_d_ff  <= W_OPER'(ww_ff) + W_OPER'(xx_ff) - W_OPER'(yy_ff) - W_OPER'(zz_ff);
         roll_n_ff <= (W_OPER'(yz_ff) + W_OPER'(wx_ff)) <<< 1;
         roll_d_ff <= W_OPER'(ww_ff) - W_OPER'(xx_ff) - W_OPER'(yy_ff) + W_OPER'(zz_ff);
         t_ff      <= (W_OPER'(wy_ff) - W_OPER'(xz_ff)) <<< 1;
      end
   end

   // Pitch clamp detection and t squared. A clamped item carries t of zero so
   // that the square root stays in range; its angle is replaced at the end.
   side_type side_ff [0:ISQ_STAGES];
   side_type side0_in;
   logic [W_SQ-1:0] tt_ff;
   logic [29:0] tmag;

   always_comb begin
      side0_in.yaw_n     = yaw_n_ff;
      side0_in.yaw_d     = yaw_d_ff;
      side0_in.roll_n    = roll_n_ff;
      side0_in.roll_d    = roll_d_ff;
      side0_in.clamp_pos = t_ff >= UNIT_Q30;
      side0_in.clamp_neg = t_ff <= -UNIT_Q30;
      if (side0_in.clamp_pos || side0_in.clamp_neg) side0_in.t = '0;
      else side0_in.t = W_T'(t_ff);
      tmag = side0_in.t[W_T-1] ? 30'(-side0_in.t) : 30'(side0_in.t);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side0_in;
         tt_ff      <= W_SQ'(tmag) * W_SQ'(tmag);
      end
   end

   // Square-root chain for the pitch cosine, with the other operands riding alongside.
   isq_type isq [0:ISQ_STAGES];
   assign isq[0] = '{n: ONE_Q60 - tt_ff, res: '0};

   genvar gi;
   generate
      for (gi = 0; gi < ISQ_STAGES; gi++) begin : g_isq
         qte_isqrt_cell #(.STAGE(gi)) u_cell (
            .clock (clock),
            .en    (en),
            .d_in  (isq[gi]),
            .d_out (isq[gi+1])
         );
         always_ff @(posedge clock) begin
            if (en) side_ff[gi+1] <= side_ff[gi];
         end
      end
   endgenerate

   // Prerotation, then three parallel CORDIC chains.
   cordic_vec_type yaw_v [0:CORDIC_STAGES];
   cordic_vec_type roll_v [0:CORDIC_STAGES];
   cordic_vec_type pit_v [0:CORDIC_STAGES];
   logic [1:0] clamp_ff [0:CORDIC_STAGES];
   side_type sd;

   assign sd = side_ff[ISQ_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_v[0]    <= prerotate(W_VEC'(sd.yaw_n), W_VEC'(sd.yaw_d));
         roll_v[0]   <= prerotate(W_VEC'(sd.roll_n), W_VEC'(sd.roll_d));
         pit_v[0]    <= prerotate(W_VEC'(sd.t), W_VEC'(isq[ISQ_STAGES].res));
         clamp_ff[0] <= {sd.clamp_neg, sd.clamp_pos};
      end
   end

   generate
      for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
         qte_cordic_cell #(.STAGE(gi)) u_yaw (
            .clock (clock), .en (en), .v_in (yaw_v[gi]), .v_out (yaw_v[gi+1])
         );
         qte_cordic_cell #(.STAGE(gi)) u_roll (
            .clock (clock), .en (en), .v_in (roll_v[gi]), .v_out (roll_v[gi+1])
         );
         qte_cordic_cell #(.STAGE(gi)) u_pitch (
            .clock (clock), .en (en), .v_in (pit_v[gi]), .v_out (pit_v[gi+1])
         );
         always_ff @(posedge clock) begin
            if (en) clamp_ff[gi+1] <= clamp_ff[gi];
         end
      end
   endgenerate

   // Output register: rounding to Q3.13, saturation and the special cases.
   logic signed [W_Q13-1:0] yaw_in, roll_in, pitch_in;
   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;

   always_comb begin
      cordic_vec_type yl, rl, pl;
      yl = yaw_v[CORDIC_STAGES];
      rl = roll_v[CORDIC_STAGES];
      pl = pit_v[CORDIC_STAGES];
      yaw_in  = yl.zero ? '0 : to_q13(yl.z, PI_Q13);
      roll_in = rl.zero ? '0 : to_q13(rl.z, PI_Q13);
      if (clamp_ff[CORDIC_STAGES][0]) pitch_in = HALF_PI_Q13;
      else if (clamp_ff[CORDIC_STAGES][1]) pitch_in = -HALF_PI_Q13;
      else if (pl.zero) pitch_in = '0;
      else pitch_in = to_q13(pl.z, HALF_PI_Q13);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_ff   <= yaw_in[15:0];
         roll_ff  <= roll_in[15:0];
         pitch_ff <= pitch_in[14:0];
      end
   end

   assign rsp_tdata = {1'b0, roll_ff, pitch_ff, yaw_ff};

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the quaternion to ZYX Euler angle pipeline.
// Depends on qte_pkg and quaternion_to_euler_angles_top; it predicts every angle set itself.
`timescale 1ns / 1ps

// Holds the angle sets still owed by the block and checks each one that comes out.
class angle_scoreboard;
   logic [46:0] owed_angles[$];
   int          error_count;
   int          checked_count;

   // Floor shift of a signed 64-bit value.
   static function longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   static function longint arc_step(int i);
      longint unsigned total;
      longint unsigned term;
      int k;
      bit add;
      total = 0;
      add = 1'b1;
      if (i == 0) return 64'sd843314857;
      for (k = 1; k * i <= 60; k += 2) begin
         term = (64'd1 << (60 - k * i)) / k;
         total = add ? total + term : total - term;
         add = !add;
      end
      return longint'((total + (64'd1 << 29)) >> 30);
   endfunction

   static function longint vector_angle(longint y, longint x);
      longint z;
      longint t;
      longint xs;
      longint ys;
      int i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 64'sd1686629713;
         end else begin
            x = -y;
            y = t;
            z = -64'sd1686629713;
         end
      end
      for (i = 0; i < 16; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arc_step(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arc_step(i);
         end
      end
      return z;
   endfunction

   static function longint round_q13(longint a, longint lim);
      longint r;
      r = shr_floor(a + 65536, 17);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Works out yaw, pitch and roll for one accepted quaternion.
   function void note_quaternion(logic [63:0] q);
      longint w;
      longint x;
      longint y;
      longint z;
      longint t;
      longint yaw;
      longint pitch;
      longint roll;
      longint unsigned tt;
      logic [15:0] yaw_bits;
      logic [14:0] pitch_bits;
      logic [15:0] roll_bits;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      yaw = round_q13(vector_angle(2 * (x * y + w * z), w*w + x*x - y*y - z*z), 25736);
      roll = round_q13(vector_angle(2 * (y * z + w * x), w*w - x*x - y*y + z*z), 25736);
      t = 2 * (w * y - x * z);
      if (t >= 64'sd1073741824) begin
         pitch = 12868;
      end else if (t <= -64'sd1073741824) begin
         pitch = -12868;
      end else begin
         tt = longint'(t * t);
         pitch = round_q13(vector_angle(t, longint'(int_sqrt((64'd1 << 60) - tt))), 12868);
      end
      yaw_bits = yaw[15:0];
      pitch_bits = pitch[14:0];
      roll_bits = roll[15:0];
      owed_angles.push_back({roll_bits, pitch_bits, yaw_bits});
   endfunction

   function void check_angles(logic [47:0] r);
      logic [46:0] e;
      checked_count++;
      if (owed_angles.size() == 0) begin
         $error("angle set arrived with none expected: %h", r);
         error_count++;
         return;
      end
      e = owed_angles.pop_front();
      if (r[15:0] !== e[15:0]) begin
         $error("yaw_angle expected %0d actual %0d", $signed(e[15:0]), $signed(r[15:0]));
         error_count++;
      end
      if (r[30:16] !== e[30:16]) begin
         $error("pitch_angle expected %0d actual %0d", $signed(e[30:16]),
                $signed(r[30:16]));
         error_count++;
      end
      if (r[46:31] !== e[46:31]) begin
         $error("roll_angle expected %0d actual %0d", $signed(e[46:31]),
                $signed(r[46:31]));
         error_count++;
      end
   endfunction
endclass

module testbench;
   import qte_pkg::*;

   localparam int LATENCY = 37 + 16;
   localparam int RANDOM_ITEMS = 1900;
   localparam longint CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [63:0] req_tdata;
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [47:0] rsp_tdata;

   angle_scoreboard angles;
   longint cycle_count;
   bit     stimulus_done;
   int     sent_count;

   quaternion_to_euler_angles_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Presents one item and holds it until the block takes it. Valid stays high
   // after the handshake so that a following item can go out with no gap.
   task automatic send_item(input logic [63:0] q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angles.note_quaternion(q);
      sent_count++;
   endtask

   task automatic send_parts(input int w, input int x, input int y, input int z);
      send_item({z[15:0], y[15:0], x[15:0], w[15:0]});
   endtask

   // Random unit-ish quaternion: a random direction scaled so that its largest component has
   // magnitude 23170, so the pitch argument spans the whole open interval and the clamp region too.
   function automatic logic [63:0] unitish_quaternion();
      int c[4];
      int m;
      int k;
      m = 0;
      for (k = 0; k < 4; k++) begin
         c[k] = $signed($urandom_range(0, 65535)) - 32768;
         if (c[k] < 0 && -c[k] > m) m = -c[k];
         if (c[k] > m) m = c[k];
      end
      if (m == 0) m = 1;
      for (k = 0; k < 4; k++) c[k] = (c[k] * 23170) / m;
      return {c[3][15:0], c[2][15:0], c[1][15:0], c[0][15:0]};
   endfunction

   // Result side: stalls at random and hands every taken angle set to the checker.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid) angles.check_angles(rsp_tdata);
      end
   end

   // The watchdog counts cycles and ends a run that hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int k;
      angles = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      stimulus_done = 1'b0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: identity, all zeros (both arctangent operands zero),
      // single axes where one operand is zero, field extremes, and pitch
      // just below and just beyond the clamp.
      send_parts(16'sd32767, 0, 0, 0);
      send_parts(0, 0, 0, 0);
      send_parts(0, 16'sd32767, 0, 0);
      send_parts(0, 0, 16'sd32767, 0);
      send_parts(0, 0, 0, 16'sd32767);
      send_parts(16'h8000, 0, 0, 0);
      send_parts(0, 16'h8000, 0, 0);
      send_parts(0, 0, 16'h8000, 0);
      send_parts(0, 0, 0, 16'h8000);
      send_parts(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_parts(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_parts(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_parts(16'sd23170, 0, 16'sd23170, 0);
      send_parts(16'sd23170, 0, -16'sd23170, 0);
      send_parts(16'sd23170, 16'sd23170, 0, 0);
      send_parts(16'sd23170, 0, 0, 16'sd23170);
      send_parts(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
      send_parts(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
      send_parts(16'sd23171, 0, 16'sd23171, 0);
      send_parts(16'sd1, 0, 0, 0);
      send_parts(16'hffff, 16'hffff, 0, 0);

      // Hold off until the pipeline has drained completely.
      req_tvalid <= 1'b0;
      while (angles.owed_angles.size() != 0) @(posedge clock);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         k = $urandom_range(0, 9);
         if (k < 7) send_item(unitish_quaternion());
         else if (k < 9) send_item({$urandom, $urandom});
         else send_parts($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2,
                         $urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2);
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (angles.owed_angles.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;

      while (angles.owed_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      $display("Sent %0d quaternions (directed corners and random), checked %0d angle sets.",
               sent_count, angles.checked_count);
      if (angles.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
